// ===== src/throttle_command_mapper_core_assert.svh =====
// Assertion macros for the throttle command mapper
`ifndef THROTTLE_COMMAND_MAPPER_CORE_ASSERT_SVH
`define THROTTLE_COMMAND_MAPPER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define TCM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("throttle mapper check failed");

// next-cycle implication, clocked on clk, off during reset
`define TCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("throttle mapper check failed");

`endif

// ===== src/tcm_pkg.sv =====
package tcm_pkg;

    localparam int RAW_BITS_DEF = 10;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int TIME_W       = 32;
    localparam int SPEED_W      = 16;
    localparam int WIPER_W      = 7;
    localparam int PCT_W        = 7;
    localparam int SPD_NUM_W    = 23;

    localparam logic [CFG_IDX_W-1:0] REG_JOY_REST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JOY_FULL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_BOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_TOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SOFT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_HARD = 3'd7;

    localparam int JOY_REST_RST  = 550;
    localparam int JOY_FULL_RST  = 1023;
    localparam int KNOB_BOT_RST  = 0;
    localparam int KNOB_TOP_RST  = 1023;
    localparam logic [WIPER_W-1:0] SPAN_LOW_RST   = 7'd30;
    localparam logic [WIPER_W-1:0] SPAN_HIGH_RST  = 7'd63;
    localparam logic [SPEED_W-1:0] SPEED_SOFT_RST = 16'd2500;
    localparam logic [SPEED_W-1:0] SPEED_HARD_RST = 16'd3000;

    localparam logic [TIME_W-1:0]  UPDATE_PERIOD_MS = 32'd20;
    localparam logic [WIPER_W-1:0] WIPER_ONE_MIN    = 7'd30;
    localparam logic [WIPER_W-1:0] WIPER_ONE_MAX    = 7'd63;
    localparam logic [WIPER_W-1:0] WIPER_FLOOR      = 7'd30;
    localparam logic [PCT_W-1:0]   MIN_PCT          = 7'd5;
    localparam logic [PCT_W-1:0]   FULL_PCT         = 7'd100;

    function automatic logic [WIPER_W-1:0] clamp7(
        input logic [WIPER_W-1:0] v,
        input logic [WIPER_W-1:0] lo,
        input logic [WIPER_W-1:0] hi
    );
        logic [WIPER_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/throttle_command_mapper_core.sv =====
// Sequence: an accepted item runs the joystick map, knob map and target divisions when a remap is due, then the
// speed pull division if needed, then S_OUT; each division yields NUM_W = max(RAW_BITS+7, 23) quotient bits.
// Throughput: one item at a time, set by the shared bit-serial divider (one bit per cycle);
// ready returns as the result is loaded; an item with enabled low is taken every cycle.
// Reset: asynchronous, active low; registers to defaults, state and out_valid cleared, output data not reset.
module throttle_command_mapper_core #(
    parameter int RAW_BITS = tcm_pkg::RAW_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             enabled,
    input  logic [tcm_pkg::TIME_W-1:0]       now_ms,
    input  logic [RAW_BITS-1:0]              joystick_raw,
    input  logic [RAW_BITS-1:0]              knob_raw,
    input  logic [tcm_pkg::SPEED_W-1:0]      vehicle_speed,
    input  logic                             pedal_stopped,
    input  logic                             brake_pressed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcm_pkg::WIPER_W-1:0]      wiper_one_out,
    output logic [tcm_pkg::WIPER_W-1:0]      wiper_two_out,
    output logic [tcm_pkg::PCT_W-1:0]        joystick_pct_out,
    output logic [tcm_pkg::PCT_W-1:0]        knob_pct_out
);
    import tcm_pkg::*;

    localparam int NUM_W = (RAW_BITS + 7 > SPD_NUM_W) ? RAW_BITS + 7 : SPD_NUM_W;
    localparam int DEN_W = (RAW_BITS > SPEED_W) ? RAW_BITS : SPEED_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_JSET = 4'd1;
    localparam logic [3:0] S_JRUN = 4'd2;
    localparam logic [3:0] S_KSET = 4'd3;
    localparam logic [3:0] S_KRUN = 4'd4;
    localparam logic [3:0] S_TSET = 4'd5;
    localparam logic [3:0] S_TRUN = 4'd6;
    localparam logic [3:0] S_SPD  = 4'd7;
    localparam logic [3:0] S_SRUN = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [RAW_BITS-1:0] joy_rest_reg, joy_full_reg, knob_bot_reg, knob_top_reg;
    logic [WIPER_W-1:0]  span_lo_reg, span_hi_reg;
    logic [SPEED_W-1:0]  soft_reg, hard_reg;

    logic [TIME_W-1:0]  last_ms_reg, last_ms_next;
    logic [WIPER_W-1:0] target_reg, target_next;
    logic [WIPER_W-1:0] wiper_one_reg, wiper_one_next;
    logic [WIPER_W-1:0] wiper_two_reg, wiper_two_next;
    logic [PCT_W-1:0]   jpct_reg, jpct_next;
    logic [PCT_W-1:0]   kpct_reg, kpct_next;
    logic               out_valid_reg, out_valid_next;

    logic [RAW_BITS-1:0] jraw_reg, kraw_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [WIPER_W-1:0]  out_w1_reg, out_w2_reg;
    logic [PCT_W-1:0]    out_jp_reg, out_kp_reg;

    logic               accept;
    logic               out_load;
    logic [TIME_W-1:0]  time_gap;

    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [NUM_W-1:0]    div_quo;

    logic                sel_knob;
    logic [RAW_BITS-1:0] map_x, map_a, map_b;
    logic [RAW_BITS:0]   map_dx, map_db;
    logic [RAW_BITS-1:0] map_mx, map_mb;
    logic [NUM_W-1:0]    map_num;
    logic                map_void;
    logic [PCT_W-1:0]    map_pct;

    logic [WIPER_W:0]    span_d;
    logic [WIPER_W-1:0]  span_mag;
    logic [13:0]         t_prod;
    logic [WIPER_W-1:0]  t_val;

    logic                spd_over;
    logic [SPEED_W-1:0]  spd_n, spd_nc;
    logic [SPEED_W:0]    spd_r;
    logic                spd_r_pos;
    logic [SPD_NUM_W:0]  spd_num;
    logic [WIPER_W-1:0]  spd_direct;
    logic [WIPER_W-1:0]  spd_quo;

    tcm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign time_gap = now_ms - last_ms_reg;

    // shared percentage map for joystick and knob
    assign sel_knob = (state_reg == S_KSET) || (state_reg == S_KRUN);
    assign map_x    = sel_knob ? kraw_reg     : jraw_reg;
    assign map_a    = sel_knob ? knob_bot_reg : joy_rest_reg;
    assign map_b    = sel_knob ? knob_top_reg : joy_full_reg;
    assign map_dx   = {1'b0, map_x} - {1'b0, map_a};
    assign map_db   = {1'b0, map_b} - {1'b0, map_a};
    assign map_mx   = map_dx[RAW_BITS] ? RAW_BITS'(-map_dx) : map_dx[RAW_BITS-1:0];
    assign map_mb   = map_db[RAW_BITS] ? RAW_BITS'(-map_db) : map_db[RAW_BITS-1:0];
    assign map_num  = NUM_W'(map_mx) * NUM_W'(FULL_PCT);
    assign map_void = (map_db == '0) || (map_dx[RAW_BITS] ^ map_db[RAW_BITS]);
    assign map_pct  = map_void ? '0 :
                      (div_quo > NUM_W'(FULL_PCT)) ? FULL_PCT : div_quo[PCT_W-1:0];

    // wiper target from joystick percentage
    assign span_d   = {1'b0, span_hi_reg} - {1'b0, span_lo_reg};
    assign span_mag = span_d[WIPER_W] ? WIPER_W'(-span_d) : span_d[WIPER_W-1:0];
    assign t_prod   = 14'(jpct_reg) * 14'(span_mag);
    assign t_val    = span_d[WIPER_W] ? span_lo_reg - div_quo[WIPER_W-1:0]
                                      : span_lo_reg + div_quo[WIPER_W-1:0];

    // speed pull toward the floor
    assign spd_over   = speed_reg > soft_reg;
    assign spd_n      = speed_reg - soft_reg;
    assign spd_r      = {1'b0, hard_reg} - {1'b0, soft_reg};
    assign spd_r_pos  = !spd_r[SPEED_W] && (spd_r[SPEED_W-1:0] != '0);
    assign spd_nc     = (spd_n > spd_r[SPEED_W-1:0]) ? spd_r[SPEED_W-1:0] : spd_n;
    assign spd_num    = (SPD_NUM_W + 1)'(target_reg) * (SPD_NUM_W + 1)'(spd_r[SPEED_W-1:0] - spd_nc)
                      + (SPD_NUM_W + 1)'(WIPER_FLOOR) * (SPD_NUM_W + 1)'(spd_nc);
    assign spd_direct = (spd_r == '0) ? WIPER_FLOOR : target_reg;
    assign spd_quo    = div_quo[WIPER_W-1:0];

    always_comb
    begin
        case (state_reg)
            S_JSET, S_KSET:
            begin
                div_num = map_num;
                div_den = DEN_W'(map_mb);
            end
            S_TSET:
            begin
                div_num = NUM_W'(t_prod);
                div_den = DEN_W'(FULL_PCT);
            end
            default:
            begin
                div_num = NUM_W'(spd_num);
                div_den = DEN_W'(spd_r[SPEED_W-1:0]);
            end
        endcase
    end

    assign div_start = (state_reg == S_JSET) || (state_reg == S_KSET) || (state_reg == S_TSET)
                     || ((state_reg == S_SPD) && spd_over && spd_r_pos);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        last_ms_next   = last_ms_reg;
        target_next    = target_reg;
        wiper_one_next = wiper_one_reg;
        wiper_two_next = wiper_two_reg;
        jpct_next      = jpct_reg;
        kpct_next      = kpct_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && enabled)
                begin
                    if (pedal_stopped || brake_pressed)
                    begin
                        target_next    = '0;
                        wiper_one_next = '0;
                        wiper_two_next = '0;
                        jpct_next      = '0;
                        kpct_next      = '0;
                        state_next     = S_SPD;
                    end
                    else if (time_gap > UPDATE_PERIOD_MS)
                    begin
                        last_ms_next = now_ms;
                        state_next   = S_JSET;
                    end
                    else
                    begin
                        state_next = S_SPD;
                    end
                end
            end
            S_JSET:
            begin
                state_next = S_JRUN;
            end
            S_JRUN:
            begin
                if (div_done)
                begin
                    jpct_next  = map_pct;
                    state_next = S_KSET;
                end
            end
            S_KSET:
            begin
                state_next = S_KRUN;
            end
            S_KRUN:
            begin
                if (div_done)
                begin
                    kpct_next = map_pct;
                    if ((jpct_reg < MIN_PCT) || (map_pct < MIN_PCT))
                    begin
                        target_next    = '0;
                        wiper_one_next = '0;
                        wiper_two_next = '0;
                        state_next     = S_SPD;
                    end
                    else
                    begin
                        state_next = S_TSET;
                    end
                end
            end
            S_TSET:
            begin
                state_next = S_TRUN;
            end
            S_TRUN:
            begin
                if (div_done)
                begin
                    target_next    = t_val;
                    wiper_one_next = (t_val == '0) ? '0 :
                                     clamp7(t_val, WIPER_ONE_MIN, WIPER_ONE_MAX);
                    wiper_two_next = (t_val == '0) ? '0 :
                                     clamp7(t_val, span_lo_reg, span_hi_reg);
                    state_next     = S_SPD;
                end
            end
            S_SPD:
            begin
                if (spd_over && spd_r_pos)
                begin
                    state_next = S_SRUN;
                end
                else
                begin
                    if (spd_over)
                    begin
                        wiper_two_next = (spd_direct < WIPER_FLOOR) ? WIPER_FLOOR : spd_direct;
                    end
                    state_next = S_OUT;
                end
            end
            S_SRUN:
            begin
                if (div_done)
                begin
                    wiper_two_next = (spd_quo < WIPER_FLOOR) ? WIPER_FLOOR : spd_quo;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_ms_reg   <= '0;
            target_reg    <= '0;
            wiper_one_reg <= '0;
            wiper_two_reg <= '0;
            jpct_reg      <= '0;
            kpct_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_ms_reg   <= last_ms_next;
            target_reg    <= target_next;
            wiper_one_reg <= wiper_one_next;
            wiper_two_reg <= wiper_two_next;
            jpct_reg      <= jpct_next;
            kpct_reg      <= kpct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joy_rest_reg <= RAW_BITS'(JOY_REST_RST);
            joy_full_reg <= RAW_BITS'(JOY_FULL_RST);
            knob_bot_reg <= RAW_BITS'(KNOB_BOT_RST);
            knob_top_reg <= RAW_BITS'(KNOB_TOP_RST);
            span_lo_reg  <= SPAN_LOW_RST;
            span_hi_reg  <= SPAN_HIGH_RST;
            soft_reg     <= SPEED_SOFT_RST;
            hard_reg     <= SPEED_HARD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_JOY_REST:   joy_rest_reg <= cfg_data[RAW_BITS-1:0];
                REG_JOY_FULL:   joy_full_reg <= cfg_data[RAW_BITS-1:0];
                REG_KNOB_BOT:   knob_bot_reg <= cfg_data[RAW_BITS-1:0];
                REG_KNOB_TOP:   knob_top_reg <= cfg_data[RAW_BITS-1:0];
                REG_SPAN_LOW:   span_lo_reg  <= cfg_data[WIPER_W-1:0];
                REG_SPAN_HIGH:  span_hi_reg  <= cfg_data[WIPER_W-1:0];
                REG_SPEED_SOFT: soft_reg     <= cfg_data[SPEED_W-1:0];
                REG_SPEED_HARD: hard_reg     <= cfg_data[SPEED_W-1:0];
                default:        ;
            endcase
        end
    end

    // hold the item's readings while it is worked on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jraw_reg  <= joystick_raw;
            kraw_reg  <= knob_raw;
            speed_reg <= vehicle_speed;
        end
        if (out_load)
        begin
            out_w1_reg <= wiper_one_reg;
            out_w2_reg <= wiper_two_reg;
            out_jp_reg <= jpct_reg;
            out_kp_reg <= kpct_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign wiper_one_out    = out_w1_reg;
    assign wiper_two_out    = out_w2_reg;
    assign joystick_pct_out = out_jp_reg;
    assign knob_pct_out     = out_kp_reg;

endmodule

// ===== src/tcm_div.sv =====
module tcm_div #(
    parameter int NUM_W = tcm_pkg::SPD_NUM_W,
    parameter int DEN_W = tcm_pkg::SPEED_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    import tcm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[DEN_W+1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = num;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            rem_next   = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next   = {quo_reg[NUM_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/tcm_checker.sv =====
`include "throttle_command_mapper_core_assert.svh"

module tcm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        enabled,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tcm_pkg::WIPER_W-1:0] wiper_one_out,
    input logic [tcm_pkg::WIPER_W-1:0] wiper_two_out,
    input logic [tcm_pkg::PCT_W-1:0]   joystick_pct_out,
    input logic [tcm_pkg::PCT_W-1:0]   knob_pct_out
);
    import tcm_pkg::*;

    // hold a stalled result beat
    `TCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(wiper_one_out) && $stable(wiper_two_out) && $stable(joystick_pct_out) && $stable(knob_pct_out))

    `TCM_ASSERT_IMPL(a_pct_range, out_valid, (joystick_pct_out <= FULL_PCT) && (knob_pct_out <= FULL_PCT))

    `TCM_ASSERT_IMPL(a_wiper_one_range, out_valid, (wiper_one_out == '0) || ((wiper_one_out >= WIPER_ONE_MIN) && (wiper_one_out <= WIPER_ONE_MAX)))

    `TCM_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready && enabled, !in_ready)

    `TCM_ASSERT_NEXT(a_no_result_when_off, in_valid && in_ready && !enabled && !out_valid, !out_valid)

endmodule

bind throttle_command_mapper_core tcm_checker u_tcm_checker (.*);
